FILE: rtl/log_text_escape_cleaner_top_defines.svh
`ifndef LOG_TEXT_ESCAPE_CLEANER_TOP_DEFINES_SVH
`define LOG_TEXT_ESCAPE_CLEANER_TOP_DEFINES_SVH

// check a property outside reset
`define LTEC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ltec check failed");

// check a property that spans reset
`define LTEC_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ltec check failed across reset");

`endif

FILE: rtl/ltec_pkg.sv
package ltec_pkg;

  localparam logic [2:0] MODE_NORMAL  = 3'd0;
  localparam logic [2:0] MODE_BSL     = 3'd1;
  localparam logic [2:0] MODE_BSL_X   = 3'd2;
  localparam logic [2:0] MODE_BSL_X_D = 3'd3;
  localparam logic [2:0] MODE_ESC     = 3'd4;
  localparam logic [2:0] MODE_CSI     = 3'd5;

  localparam logic [15:0] CH_BSL = 16'h005C;
  localparam logic [15:0] CH_SOH = 16'h0001;
  localparam logic [15:0] CH_ESC = 16'h001B;
  localparam logic [15:0] CH_X   = 16'h0078;
  localparam logic [15:0] CH_LBR = 16'h005B;
  localparam logic [15:0] HEX_TEN = 16'd10;

  localparam int MAX_RES = 4;

  typedef struct packed {
    logic [MAX_RES-1:0][15:0] ch;
    logic [2:0]               n;
  } list_t;

  typedef struct packed {
    logic [MAX_RES-1:0][15:0] ch;
    logic [1:0]               cnt_m1;
    logic                     any;
    logic                     has_char;
    logic [2:0]               mode_next;
    logic [15:0]              held_next;
  } dec_t;

  function automatic list_t push(list_t l, logic [15:0] v);
    list_t r;
    r = l;
    if (l.n < 3'(MAX_RES)) begin
      r.ch[l.n[1:0]] = v;
      r.n = l.n + 3'd1;
    end
    return r;
  endfunction

  function automatic logic [4:0] hex_of(logic [15:0] u);
    logic [15:0] v;
    v = 16'd0;
    if (u inside {[16'h0030:16'h0039]}) begin
      return {1'b1, u[3:0]};
    end else if (u inside {[16'h0041:16'h0046]}) begin
      v = u - 16'h0041 + HEX_TEN;
      return {1'b1, v[3:0]};
    end else if (u inside {[16'h0061:16'h0066]}) begin
      v = u - 16'h0061 + HEX_TEN;
      return {1'b1, v[3:0]};
    end
    return 5'd0;
  endfunction

  function automatic logic is_letter(logic [15:0] u);
    return u inside {[16'h0041:16'h005A], [16'h0061:16'h007A]};
  endfunction

  function automatic logic [2:0] fresh_mode(logic [15:0] c);
    if (c == CH_BSL) begin
      return MODE_BSL;
    end else if (c == CH_ESC) begin
      return MODE_ESC;
    end
    return MODE_NORMAL;
  endfunction

  function automatic list_t fresh_push(list_t l, logic [15:0] c);
    if (c == CH_SOH || c == CH_BSL || c == CH_ESC) begin
      return l;
    end
    return push(l, c);
  endfunction

endpackage

FILE: rtl/ltec_decode.sv
module ltec_decode (
  input  logic [2:0]     mode,
  input  logic [15:0]    held,
  input  logic [15:0]    c,
  input  logic           last,
  output ltec_pkg::dec_t dec
);
  import ltec_pkg::*;

  list_t      l;
  logic [2:0] m;
  logic [15:0] h;
  logic [4:0] hc;
  logic [4:0] hh;

  always_comb begin
    l  = '0;
    m  = MODE_NORMAL;
    h  = 16'd0;
    hc = hex_of(c);
    hh = hex_of(held);
    case (mode)
      MODE_BSL: begin
        if (c == CH_X) begin
          m = MODE_BSL_X;
        end else begin
          l = push(l, CH_BSL);
          l = fresh_push(l, c);
          m = fresh_mode(c);
        end
      end
      MODE_BSL_X: begin
        if (hc[4]) begin
          h = c;
          m = MODE_BSL_X_D;
        end else begin
          l = push(l, CH_BSL);
          l = push(l, CH_X);
          l = fresh_push(l, c);
          m = fresh_mode(c);
        end
      end
      MODE_BSL_X_D: begin
        if (hc[4]) begin
          l = push(l, {8'h00, hh[3:0], hc[3:0]});
        end else begin
          l = push(l, CH_BSL);
          l = push(l, CH_X);
          l = push(l, held);
          l = fresh_push(l, c);
          m = fresh_mode(c);
        end
      end
      MODE_ESC: begin
        if (c == CH_LBR) begin
          m = MODE_CSI;
        end else begin
          l = fresh_push(l, c);
          m = fresh_mode(c);
        end
      end
      MODE_CSI: begin
        m = is_letter(c) ? MODE_NORMAL : MODE_CSI;
      end
      default: begin
        l = fresh_push(l, c);
        m = fresh_mode(c);
      end
    endcase

    if (last) begin
      if (m == MODE_BSL) begin
        l = push(l, CH_BSL);
      end else if (m == MODE_BSL_X) begin
        l = push(l, CH_BSL);
        l = push(l, CH_X);
      end else if (m == MODE_BSL_X_D) begin
        l = push(l, CH_BSL);
        l = push(l, CH_X);
        l = push(l, h);
      end
      m = MODE_NORMAL;
      h = 16'd0;
    end

    dec.ch        = l.ch;
    dec.has_char  = (l.n != 3'd0);
    dec.any       = (l.n != 3'd0) || last;
    dec.cnt_m1    = (l.n == 3'd0) ? 2'd0 : 2'(l.n - 3'd1);
    dec.mode_next = m;
    dec.held_next = h;
  end

endmodule

FILE: rtl/log_text_escape_cleaner_top.sv
// channel | handshake                   | payload
// in      | in_valid / in_stall         | in_char, is_last
// out     | out_valid / out_stall       | out_char, has_char, run_last, string_end
//
// One input transaction per cycle while in_stall is low; an item with n results holds the input
// side while the result buffer drains one result per cycle when out_stall is low.
// Input to first result passes the input register, then the result buffer.
// rst is synchronous: clears both valid flags, the parse mode and the held digit.
// out_stall holds the result buffer; once the input register holds an item with results
// and the buffer is not free, in_stall rises.
module log_text_escape_cleaner_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_char,
  input  logic        is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_char,
  output logic        has_char,
  output logic        run_last,
  output logic        string_end
);
  import ltec_pkg::*;

  logic        rv;
  logic [15:0] rc;
  logic        rl;

  logic [2:0]  mode;
  logic [15:0] held;

  logic                     bv;
  logic [MAX_RES-1:0][15:0] bch;
  logic [1:0]               bcnt_m1;
  logic [1:0]               bidx;
  logic                     bhas;
  logic                     bend;

  dec_t dec;
  logic out_take;
  logic buf_free;
  logic move;

  ltec_decode u_decode (
    .mode (mode),
    .held (held),
    .c    (rc),
    .last (rl),
    .dec  (dec)
  );

  assign out_take = bv && !out_stall;
  assign buf_free = !bv || (out_take && bidx == bcnt_m1);
  assign move     = rv && (!dec.any || buf_free);
  assign in_stall = rv && !move;

  always_ff @(posedge clk) begin
    if (rst) begin
      rv <= 1'b0;
    end else if (in_valid && !in_stall) begin
      rv <= 1'b1;
    end else if (move) begin
      rv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      rc <= in_char;
      rl <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NORMAL;
      held <= 16'd0;
    end else if (move) begin
      mode <= dec.mode_next;
      held <= dec.held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bv   <= 1'b0;
      bidx <= 2'd0;
    end else if (move && dec.any) begin
      bv   <= 1'b1;
      bidx <= 2'd0;
    end else if (out_take) begin
      if (bidx == bcnt_m1) begin
        bv <= 1'b0;
      end
      bidx <= bidx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (move && dec.any) begin
      bch     <= dec.ch;
      bcnt_m1 <= dec.cnt_m1;
      bhas    <= dec.has_char;
      bend    <= rl;
    end
  end

  assign out_valid  = bv;
  assign out_char   = bhas ? bch[bidx] : 16'd0;
  assign has_char   = bhas;
  assign run_last   = (bidx == bcnt_m1);
  assign string_end = (bidx == bcnt_m1) && bend;

endmodule

FILE: rtl/ltec_checker.sv
`include "log_text_escape_cleaner_top_defines.svh"

module ltec_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_char,
  input logic        has_char,
  input logic        run_last,
  input logic        string_end
);

  `LTEC_ASSERT_RST(a_rst_clears_out, rst |=> !out_valid)
  `LTEC_ASSERT(a_stall_holds, out_valid && out_stall |=> out_valid && $stable(out_char))
  `LTEC_ASSERT(a_end_is_run_last, out_valid && string_end |-> run_last)
  `LTEC_ASSERT(a_bare_marker, out_valid && !has_char |-> out_char == 16'd0 && string_end)

endmodule

bind log_text_escape_cleaner_top ltec_checker u_ltec_checker (.*);

FILE: dv/log_text_escape_cleaner_top_tb.sv
module log_text_escape_cleaner_top_tb;
  import ltec_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD = 300;

  typedef struct packed {
    logic [15:0] ch;
    logic        has_ch;
    logic        run_end;
    logic        str_end;
  } unit_res_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] in_char;
  logic        is_last;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_char;
  logic        has_char;
  logic        run_last;
  logic        string_end;

  logic [15:0] edge_chars [10] = '{16'h002F, 16'h003A, 16'h0040, 16'h0047, 16'h0060,
                                   16'h0067, 16'h005A, 16'h005B, 16'h007A, 16'h007B};

  function automatic int hex_nibble(logic [15:0] u);
    if (u >= 16'h0030 && u <= 16'h0039) return int'(u - 16'h0030);
    if (u >= 16'h0041 && u <= 16'h0046) return int'(u - 16'h0041) + 10;
    if (u >= 16'h0061 && u <= 16'h0066) return int'(u - 16'h0061) + 10;
    return -1;
  endfunction

  function automatic bit is_alpha(logic [15:0] u);
    return (u >= 16'h0041 && u <= 16'h005A) || (u >= 16'h0061 && u <= 16'h007A);
  endfunction

  class clean_text_board;
    unit_res_t   pending[$];
    logic [15:0] emitted[$];
    logic [2:0]  mode;
    logic [15:0] held;
    int          errors;

    function new();
      mode = MODE_NORMAL;
      held = '0;
      errors = 0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void put(logic [15:0] c);
      if (emitted.size() < MAX_RES) emitted.push_back(c);
    endfunction

    function void take_fresh(logic [15:0] c);
      mode = MODE_NORMAL;
      held = '0;
      if (c == CH_SOH) return;
      if (c == CH_BSL) begin
        mode = MODE_BSL;
        return;
      end
      if (c == CH_ESC) begin
        mode = MODE_ESC;
        return;
      end
      put(c);
    endfunction

    function void note_unit(logic [15:0] c, logic last);
      int hv;
      unit_res_t r;
      emitted.delete();
      hv = hex_nibble(c);
      case (mode)
        MODE_BSL: begin
          if (c == CH_X) begin
            mode = MODE_BSL_X;
          end else begin
            put(CH_BSL);
            take_fresh(c);
          end
        end
        MODE_BSL_X: begin
          if (hv >= 0) begin
            held = c;
            mode = MODE_BSL_X_D;
          end else begin
            put(CH_BSL);
            put(CH_X);
            take_fresh(c);
          end
        end
        MODE_BSL_X_D: begin
          if (hv >= 0) begin
            put({8'h00, 4'(hex_nibble(held)), 4'(hv)});
            mode = MODE_NORMAL;
            held = '0;
          end else begin
            put(CH_BSL);
            put(CH_X);
            put(held);
            take_fresh(c);
          end
        end
        MODE_ESC: begin
          if (c == CH_LBR) mode = MODE_CSI;
          else take_fresh(c);
        end
        MODE_CSI: begin
          if (is_alpha(c)) mode = MODE_NORMAL;
        end
        default: take_fresh(c);
      endcase
      if (last) begin
        if (mode == MODE_BSL) begin
          put(CH_BSL);
        end else if (mode == MODE_BSL_X) begin
          put(CH_BSL);
          put(CH_X);
        end else if (mode == MODE_BSL_X_D) begin
          put(CH_BSL);
          put(CH_X);
          put(held);
        end
        mode = MODE_NORMAL;
        held = '0;
      end
      if (emitted.size() == 0) begin
        if (last) begin
          r = '{ch: 16'h0000, has_ch: 1'b0, run_end: 1'b1, str_end: 1'b1};
          pending.push_back(r);
        end
        return;
      end
      foreach (emitted[k]) begin
        r.ch = emitted[k];
        r.has_ch = 1'b1;
        r.run_end = (k == emitted.size() - 1);
        r.str_end = (k == emitted.size() - 1) && last;
        pending.push_back(r);
      end
    endfunction

    function void check_unit(unit_res_t got);
      unit_res_t want;
      if (pending.size() == 0) begin
        flag($sformatf("unexpected result: char %h has %b run_last %b string_end %b",
                       got.ch, got.has_ch, got.run_end, got.str_end));
        return;
      end
      want = pending.pop_front();
      if (got !== want)
        flag($sformatf("mismatch: exp char %h has %b run_last %b string_end %b, got %h %b %b %b",
                       want.ch, want.has_ch, want.run_end, want.str_end,
                       got.ch, got.has_ch, got.run_end, got.str_end));
    endfunction
  endclass

  clean_text_board board;
  logic [16:0] plan[$];
  bit          sender_idle_on;
  bit          sink_idle_on;
  bit          hold_req;
  int          cycle_count;

  log_text_escape_cleaner_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_char    (in_char),
    .is_last    (is_last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_char   (out_char),
    .has_char   (has_char),
    .run_last   (run_last),
    .string_end (string_end)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] pick_any();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 16'($urandom_range(16'h0020, 16'h007E));
      6: return edge_chars[$urandom_range(0, 9)];
      7: return 16'($urandom_range(0, 16'h001F));
      8: return 16'($urandom_range(0, 16'hFFFF));
      default: return 16'($urandom_range(16'hFF00, 16'hFFFF));
    endcase
  endfunction

  function automatic logic [15:0] pick_hex();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return 16'h0030 + 16'(r);
    if (r < 16) return 16'h0041 + 16'(r - 10);
    return 16'h0061 + 16'(r - 16);
  endfunction

  function automatic logic [15:0] pick_non_hex();
    logic [15:0] c;
    do c = pick_any(); while (hex_nibble(c) >= 0);
    return c;
  endfunction

  function automatic logic [15:0] pick_letter();
    if ($urandom_range(0, 1)) return 16'($urandom_range(16'h0041, 16'h005A));
    return 16'($urandom_range(16'h0061, 16'h007A));
  endfunction

  task automatic queue_unit(logic [15:0] c, logic last);
    plan.push_back({last, c});
  endtask

  task automatic queue_text(string s, logic last);
    for (int i = 0; i < s.len(); i++)
      queue_unit(16'(s[i]), last && (i == s.len() - 1));
  endtask

  task automatic queue_token();
    logic [15:0] c;
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      queue_unit(pick_any(), 1'b0);
    end else if (r < 35) begin
      queue_unit(CH_SOH, 1'b0);
    end else if (r < 55) begin
      queue_unit(CH_BSL, 1'b0);
      queue_unit(CH_X, 1'b0);
      queue_unit(pick_hex(), 1'b0);
      queue_unit(pick_hex(), 1'b0);
    end else if (r < 65) begin
      queue_unit(CH_BSL, 1'b0);
      case ($urandom_range(0, 2))
        0: begin
          do c = pick_any(); while (c == CH_X);
          queue_unit(c, 1'b0);
        end
        1: begin
          queue_unit(CH_X, 1'b0);
          queue_unit(pick_non_hex(), 1'b0);
        end
        default: begin
          queue_unit(CH_X, 1'b0);
          queue_unit(pick_hex(), 1'b0);
          queue_unit(pick_non_hex(), 1'b0);
        end
      endcase
    end else if (r < 80) begin
      queue_unit(CH_ESC, 1'b0);
      queue_unit(CH_LBR, 1'b0);
      repeat ($urandom_range(0, 4)) begin
        if ($urandom_range(0, 4) == 0) begin
          do c = pick_any(); while (is_alpha(c));
        end else if ($urandom_range(0, 3) == 0) begin
          c = 16'h003B;
        end else begin
          c = 16'($urandom_range(16'h0030, 16'h0039));
        end
        queue_unit(c, 1'b0);
      end
      queue_unit(pick_letter(), 1'b0);
    end else if (r < 88) begin
      queue_unit(CH_ESC, 1'b0);
      do c = pick_any(); while (c == CH_LBR);
      queue_unit(c, 1'b0);
    end else begin
      queue_unit(edge_chars[$urandom_range(0, 9)], 1'b0);
    end
  endtask

  task automatic queue_open_tail();
    case ($urandom_range(0, 5))
      0: queue_unit(CH_BSL, 1'b0);
      1: begin
        queue_unit(CH_BSL, 1'b0);
        queue_unit(CH_X, 1'b0);
      end
      2: begin
        queue_unit(CH_BSL, 1'b0);
        queue_unit(CH_X, 1'b0);
        queue_unit(pick_hex(), 1'b0);
      end
      3: queue_unit(CH_ESC, 1'b0);
      4: begin
        queue_unit(CH_ESC, 1'b0);
        queue_unit(CH_LBR, 1'b0);
      end
      default: begin
        queue_unit(CH_ESC, 1'b0);
        queue_unit(CH_LBR, 1'b0);
        queue_unit(16'h0031, 1'b0);
      end
    endcase
  endtask

  task automatic queue_strings(int count);
    while (plan.size() < count) begin
      repeat ($urandom_range(1, 8)) queue_token();
      if ($urandom_range(0, 4) == 0) queue_open_tail();
      plan[$][16] = 1'b1;
    end
  endtask

  task automatic drive_plan();
    int gap;
    foreach (plan[i]) begin
      gap = sender_idle_on ? pick_gap() : 0;
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
        in_char <= 16'($urandom);
        is_last <= 1'($urandom);
      end
      @(negedge clk);
      in_valid <= 1'b1;
      in_char <= plan[i][15:0];
      is_last <= plan[i][16];
      @(posedge clk);
      while (in_stall) @(posedge clk);
      board.note_unit(plan[i][15:0], plan[i][16]);
    end
    plan.delete();
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    int hold_left;
    int stall_left;
    hold_left = 0;
    stall_left = 0;
    out_stall = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (sink_idle_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_unit('{ch: out_char, has_ch: has_char, run_end: run_last,
                         str_end: string_end});
  end

  initial begin
    board = new();
    cycle_count = 0;
    hold_req = 1'b0;
    sender_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    rst = 1'b1;
    in_valid = 1'b0;
    in_char = '0;
    is_last = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    queue_unit(16'hFFFF, 1'b0);
    queue_unit(16'h0000, 1'b0);
    queue_unit(CH_SOH, 1'b1);
    queue_text("\\xFf\\x4g", 1'b1);
    queue_text("\\q\\x\\", 1'b1);
    queue_unit(CH_ESC, 1'b0);
    queue_text("[3mZ", 1'b0);
    queue_unit(CH_ESC, 1'b0);
    queue_text("Q", 1'b0);
    queue_unit(CH_ESC, 1'b0);
    queue_text("[", 1'b1);
    queue_text("\\xa", 1'b1);
    queue_text("\\x", 1'b1);
    queue_unit(CH_ESC, 1'b1);
    drive_plan();
    drain();

    sender_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    queue_strings(110);
    drive_plan();
    drain();

    sender_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    hold_req = 1'b1;
    queue_strings(210);
    drive_plan();
    drain();

    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule

FILE: sim.f
+incdir+rtl
rtl/ltec_pkg.sv
rtl/ltec_decode.sv
rtl/log_text_escape_cleaner_top.sv
rtl/ltec_checker.sv
dv/log_text_escape_cleaner_top_tb.sv
